@@ hw/rtl/slws_pkg.sv @@
// types, register indexes and reset values for the status led / watchdog supervisor
// no dependencies
package slws_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned PeriodW   = 16;
  localparam int unsigned SpeedW    = 16;
  localparam int unsigned ThreshW   = 15;

  localparam logic [CfgIndexW-1:0] RegLedTimeout = 3'd0;
  localparam logic [CfgIndexW-1:0] RegLedDebug   = 3'd1;
  localparam logic [CfgIndexW-1:0] RegLedMove    = 3'd2;
  localparam logic [CfgIndexW-1:0] RegLedNormal  = 3'd3;
  localparam logic [CfgIndexW-1:0] RegWdgCheck   = 3'd4;
  localparam logic [CfgIndexW-1:0] RegWdgDelay   = 3'd5;
  localparam logic [CfgIndexW-1:0] RegMoveThresh = 3'd6;

  localparam logic [PeriodW-1:0] LedTimeoutReset = 16'd100;
  localparam logic [PeriodW-1:0] LedDebugReset   = 16'd250;
  localparam logic [PeriodW-1:0] LedMoveReset    = 16'd500;
  localparam logic [PeriodW-1:0] LedNormalReset  = 16'd1000;
  localparam logic [PeriodW-1:0] WdgCheckReset   = 16'd100;
  localparam logic [PeriodW-1:0] WdgDelayReset   = 16'd3000;
  localparam logic [ThreshW-1:0] MoveThreshReset = 15'd5;

  typedef struct packed {
    logic [PeriodW-1:0]       elapsed_ms;
    logic                     estop;
    logic                     ultra_stop;
    logic                     link_timeout;
    logic                     debug_mode;
    logic signed [SpeedW-1:0] target_left;
    logic signed [SpeedW-1:0] target_right;
    logic signed [SpeedW-1:0] measured_left;
    logic signed [SpeedW-1:0] measured_right;
    logic                     all_healthy;
  } in_word_t;

  typedef struct packed {
    logic led_level;
    logic wdg_start;
    logic wdg_feed;
    logic wdg_running;
  } out_word_t;

  typedef struct packed {
    logic [PeriodW-1:0] led_timeout_period;
    logic [PeriodW-1:0] led_debug_period;
    logic [PeriodW-1:0] led_move_period;
    logic [PeriodW-1:0] led_normal_period;
    logic [PeriodW-1:0] wdg_check_period;
    logic [PeriodW-1:0] wdg_start_delay;
    logic [ThreshW-1:0] move_threshold;
  } cfg_regs_t;

  function automatic logic over_thresh(logic signed [SpeedW-1:0] v,
                                       logic [ThreshW-1:0] th);
    logic [SpeedW-1:0] mag;
    mag = v[SpeedW-1] ? (~v + 1'b1) : v;
    return mag > {1'b0, th};
  endfunction

endpackage

@@ hw/rtl/slws_cfg.sv @@
// configuration register file of the supervisor
// depends on slws_pkg
module slws_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slws_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [slws_pkg::PeriodW-1:0]  cfg_data,
  output slws_pkg::cfg_regs_t           regs
);
  import slws_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.led_timeout_period <= LedTimeoutReset;
      regs.led_debug_period   <= LedDebugReset;
      regs.led_move_period    <= LedMoveReset;
      regs.led_normal_period  <= LedNormalReset;
      regs.wdg_check_period   <= WdgCheckReset;
      regs.wdg_start_delay    <= WdgDelayReset;
      regs.move_threshold     <= MoveThreshReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegLedTimeout: regs.led_timeout_period <= cfg_data;
        RegLedDebug:   regs.led_debug_period   <= cfg_data;
        RegLedMove:    regs.led_move_period    <= cfg_data;
        RegLedNormal:  regs.led_normal_period  <= cfg_data;
        RegWdgCheck:   regs.wdg_check_period   <= cfg_data;
        RegWdgDelay:   regs.wdg_start_delay    <= cfg_data;
        RegMoveThresh: regs.move_threshold     <= cfg_data[ThreshW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/slws_core.sv @@
// led blink and watchdog supervision state with the per-tick update logic
// depends on slws_pkg
module slws_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  slws_pkg::in_word_t  word,
  input  slws_pkg::cfg_regs_t regs,
  output slws_pkg::out_word_t result
);
  import slws_pkg::*;

  logic [PeriodW-1:0] led_timer, led_timer_next;
  logic               led_state, led_state_next;
  logic [PeriodW-1:0] check_timer, check_timer_next;
  logic [PeriodW-1:0] healthy_time, healthy_time_next;
  logic               started_flag, started_flag_next;

  logic               moving;
  logic [PeriodW-1:0] period;
  logic [PeriodW-1:0] led_sum;
  logic [PeriodW-1:0] check_sum;
  logic [PeriodW:0]   healthy_sum;
  logic [PeriodW-1:0] healthy_upd;
  logic               start, feed;

  always_comb begin
    moving = over_thresh(word.target_left, regs.move_threshold)
           | over_thresh(word.target_right, regs.move_threshold)
           | over_thresh(word.measured_left, regs.move_threshold)
           | over_thresh(word.measured_right, regs.move_threshold);
    priority if (word.link_timeout) period = regs.led_timeout_period;
    else if (word.debug_mode)       period = regs.led_debug_period;
    else if (moving)                period = regs.led_move_period;
    else                            period = regs.led_normal_period;

    led_sum = led_timer + word.elapsed_ms;
    led_timer_next = led_sum;
    led_state_next = led_state;
    if (word.estop || word.ultra_stop) begin
      led_state_next = 1'b1;
      led_timer_next = '0;
    end else if (led_sum >= period) begin
      led_timer_next = '0;
      led_state_next = ~led_state;
    end

    check_sum = check_timer + word.elapsed_ms;
    check_timer_next = check_sum;
    healthy_time_next = healthy_time;
    started_flag_next = started_flag;
    start = 1'b0;
    feed = 1'b0;
    healthy_sum = {1'b0, healthy_time} + {1'b0, regs.wdg_check_period};
    healthy_upd = healthy_time;
    if (healthy_time < regs.wdg_start_delay) begin
      healthy_upd = healthy_sum[PeriodW] ? '1 : healthy_sum[PeriodW-1:0];
    end
    if (check_sum >= regs.wdg_check_period) begin
      check_timer_next = '0;
      if (!started_flag) begin
        if (word.all_healthy) begin
          healthy_time_next = healthy_upd;
          if (healthy_upd >= regs.wdg_start_delay) begin
            start = 1'b1;
            feed = 1'b1;
            started_flag_next = 1'b1;
          end
        end else begin
          healthy_time_next = '0;
        end
      end else begin
        feed = word.all_healthy;
      end
    end

    result.led_level   = led_state_next;
    result.wdg_start   = start;
    result.wdg_feed    = feed;
    result.wdg_running = started_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_timer    <= '0;
      led_state    <= 1'b0;
      check_timer  <= '0;
      healthy_time <= '0;
      started_flag <= 1'b0;
    end else if (step) begin
      led_timer    <= led_timer_next;
      led_state    <= led_state_next;
      check_timer  <= check_timer_next;
      healthy_time <= healthy_time_next;
      started_flag <= started_flag_next;
    end
  end

endmodule

@@ hw/rtl/status_led_watchdog_supervisor.sv @@
// status led and watchdog supervisor, top level
// depends on slws_pkg, slws_cfg, slws_core
//
// usage:
//   in channel (in_valid, in_stall, in_word) carries one tick word: elapsed
//   ms, stop and mode flags, four wheel speeds and the health flag.
//   out channel (out_valid, out_stall, out_word) returns one word per tick:
//   led level, watchdog start and feed pulses, watchdog running.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the seven
//   period / threshold registers; cfg_ready is always high, unknown indexes
//   are dropped. write registers only while no tick is in flight.
// timing:
//   a tick is registered in the input register on accept, processed against the state
//   as it moves into the output register and held there; out_valid rises with the
//   output register. one tick per cycle sustained while out_stall stays low.
// reset (rst, synchronous): registers return to their defaults, led off,
//   all timers cleared, watchdog not started, both pipeline stages empty.
// stall: while out_stall holds a full output register, the input register
//   fills and in_stall rises; no word is lost or repeated.
module status_led_watchdog_supervisor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  slws_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output slws_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slws_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [slws_pkg::PeriodW-1:0]  cfg_data
);
  import slws_pkg::*;

  cfg_regs_t regs;
  in_word_t  tick;
  logic      tick_valid;
  logic      out_free;
  logic      step;
  out_word_t result;

  slws_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  assign out_free = !out_valid || !out_stall;
  assign step     = tick_valid && out_free;
  assign in_stall = tick_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick <= in_word;
    end
  end

  slws_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .word   (tick),
    .regs   (regs),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_word <= result;
    end
  end

endmodule

@@ hw/rtl/slws_checker.sv @@
// port-level checks for the supervisor, bound to the top level
// depends on slws_pkg and status_led_watchdog_supervisor
module slws_sva (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input slws_pkg::out_word_t out_word
);
  import slws_pkg::*;

  logic seen_running;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_running <= 1'b0;
    end else if (out_valid && !out_stall && out_word.wdg_running) begin
      seen_running <= 1'b1;
    end
  end

  a_start_feeds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.wdg_start |-> out_word.wdg_feed && out_word.wdg_running)
    else $error("start word without feed or running");

  a_running_sticks: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_running |-> out_word.wdg_running)
    else $error("watchdog running dropped");

  a_start_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_running |-> !out_word.wdg_start)
    else $error("second watchdog start");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result changed");

endmodule

bind status_led_watchdog_supervisor slws_sva u_slws_sva (.*);

@@ dv/slws_checker.sv @@
// checker for the status led / watchdog supervisor: watches the tick, result and register
// channels, predicts every result word and compares it field by field
// depends on slws_pkg
module slws_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  slws_pkg::in_word_t             in_word,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  slws_pkg::out_word_t            out_word,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [slws_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [slws_pkg::PeriodW-1:0]   cfg_data,
  output int                             errors,
  output int                             outstanding,
  output int                             ticks,
  output int                             starts,
  output int                             feeds,
  output int                             forced
);
  timeunit 1ns;
  timeprecision 1ps;
  import slws_pkg::*;

  cfg_regs_t          cfg_shadow;
  logic [PeriodW-1:0] led_timer;
  logic [PeriodW-1:0] check_timer;
  logic [PeriodW-1:0] healthy_time;
  logic               led_on;
  logic               wdg_started;
  out_word_t          expected_status[$];
  out_word_t          want_w;
  out_word_t          new_w;
  int                 result_idx;

  task automatic report(string msg);
    errors++;
    $display("mismatch at result %0d: %s", result_idx, msg);
  endtask

  function automatic logic speed_over(logic signed [SpeedW-1:0] v);
    int s;
    s = v;
    if (s < 0) s = -s;
    return s > int'(cfg_shadow.move_threshold);
  endfunction

  function automatic out_word_t tick_supervisor(in_word_t t);
    out_word_t          r;
    logic [PeriodW-1:0] period;
    logic [PeriodW:0]   sum;
    r = '0;
    if (t.estop || t.ultra_stop) begin
      led_on = 1'b1;
      led_timer = '0;
    end else begin
      if (t.link_timeout) begin
        period = cfg_shadow.led_timeout_period;
      end else if (t.debug_mode) begin
        period = cfg_shadow.led_debug_period;
      end else if (speed_over(t.target_left) || speed_over(t.target_right) ||
                   speed_over(t.measured_left) || speed_over(t.measured_right)) begin
        period = cfg_shadow.led_move_period;
      end else begin
        period = cfg_shadow.led_normal_period;
      end
      led_timer = led_timer + t.elapsed_ms;
      if (led_timer >= period) begin
        led_timer = '0;
        led_on = ~led_on;
      end
    end
    check_timer = check_timer + t.elapsed_ms;
    if (check_timer >= cfg_shadow.wdg_check_period) begin
      check_timer = '0;
      if (!wdg_started) begin
        if (t.all_healthy) begin
          if (healthy_time < cfg_shadow.wdg_start_delay) begin
            // healthy time saturates instead of wrapping
            sum = {1'b0, healthy_time} + {1'b0, cfg_shadow.wdg_check_period};
            healthy_time = sum[PeriodW] ? '1 : sum[PeriodW-1:0];
          end
          if (healthy_time >= cfg_shadow.wdg_start_delay) begin
            r.wdg_start = 1'b1;
            r.wdg_feed = 1'b1;
            wdg_started = 1'b1;
          end
        end else begin
          healthy_time = '0;
        end
      end else begin
        r.wdg_feed = t.all_healthy;
      end
    end
    r.led_level = led_on;
    r.wdg_running = wdg_started;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_shadow.led_timeout_period = LedTimeoutReset;
      cfg_shadow.led_debug_period = LedDebugReset;
      cfg_shadow.led_move_period = LedMoveReset;
      cfg_shadow.led_normal_period = LedNormalReset;
      cfg_shadow.wdg_check_period = WdgCheckReset;
      cfg_shadow.wdg_start_delay = WdgDelayReset;
      cfg_shadow.move_threshold = MoveThreshReset;
      led_timer = '0;
      check_timer = '0;
      healthy_time = '0;
      led_on = 1'b0;
      wdg_started = 1'b0;
      expected_status.delete();
      result_idx = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegLedTimeout: cfg_shadow.led_timeout_period = cfg_data;
          RegLedDebug:   cfg_shadow.led_debug_period = cfg_data;
          RegLedMove:    cfg_shadow.led_move_period = cfg_data;
          RegLedNormal:  cfg_shadow.led_normal_period = cfg_data;
          RegWdgCheck:   cfg_shadow.wdg_check_period = cfg_data;
          RegWdgDelay:   cfg_shadow.wdg_start_delay = cfg_data;
          RegMoveThresh: cfg_shadow.move_threshold = cfg_data[ThreshW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          report($sformatf("word %b with nothing pending", out_word));
        end else begin
          want_w = expected_status.pop_front();
          if (out_word.led_level !== want_w.led_level)
            report($sformatf("led_level %b, want %b", out_word.led_level, want_w.led_level));
          if (out_word.wdg_start !== want_w.wdg_start)
            report($sformatf("wdg_start %b, want %b", out_word.wdg_start, want_w.wdg_start));
          if (out_word.wdg_feed !== want_w.wdg_feed)
            report($sformatf("wdg_feed %b, want %b", out_word.wdg_feed, want_w.wdg_feed));
          if (out_word.wdg_running !== want_w.wdg_running)
            report($sformatf("wdg_running %b, want %b", out_word.wdg_running,
                             want_w.wdg_running));
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        new_w = tick_supervisor(in_word);
        expected_status.push_back(new_w);
        ticks++;
        if (new_w.wdg_start) starts++;
        if (new_w.wdg_feed) feeds++;
        if (in_word.estop || in_word.ultra_stop) forced++;
      end
    end
    outstanding = expected_status.size();
  end

endmodule

@@ dv/tb_status_led_watchdog_supervisor.sv @@
// testbench top for the status led / watchdog supervisor: clock, reset, tick stimulus,
// register phases and result-side stalls; slws_checker does the prediction and compare
// depends on slws_pkg, slws_checker and the supervisor rtl
module tb_status_led_watchdog_supervisor;
  timeunit 1ns;
  timeprecision 1ps;
  import slws_pkg::*;

  localparam int QuietLimit = 3000;
  localparam int LongHold   = 300;

  localparam logic [CfgIndexW-1:0] RegUnused = 3'd7;

  localparam logic [3:0] Calm  = 4'b0000;
  localparam logic [3:0] Estop = 4'b1000;
  localparam logic [3:0] Ustop = 4'b0100;
  localparam logic [3:0] Tmo   = 4'b0010;
  localparam logic [3:0] Dbg   = 4'b0001;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_stall;
  out_word_t            out_word;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [PeriodW-1:0]   cfg_data;

  int errors, outstanding, ticks, starts, feeds, forced;
  int quiet;

  int tx_gap_max;
  int rx_gap_max;
  int long_hold;
  int el_max;
  int healthy_pct;
  int stop_pct;

  cfg_regs_t          next_cfg;
  logic [ThreshW-1:0] cur_thresh;

  status_led_watchdog_supervisor u_top (
    .clk, .rst,
    .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  slws_checker u_chk (
    .clk, .rst,
    .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .errors, .outstanding, .ticks, .starts, .feeds, .forced
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= QuietLimit);
    $display("no handshake for %0d cycles, giving up", QuietLimit);
    $display("tb_status_led_watchdog_supervisor NOT OK");
    $finish;
  end

  // result side: random stall per word, or one long hold-off when asked
  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (!rst);
    forever begin
      if (long_hold > 0) begin
        hold = long_hold;
        long_hold = 0;
      end else begin
        hold = $urandom_range(0, rx_gap_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  task automatic send_tick(in_word_t w);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(logic [CfgIndexW-1:0] idx, logic [PeriodW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic program_regs(bit with_unused);
    put_reg(RegLedTimeout, next_cfg.led_timeout_period);
    put_reg(RegLedDebug, next_cfg.led_debug_period);
    put_reg(RegLedMove, next_cfg.led_move_period);
    put_reg(RegLedNormal, next_cfg.led_normal_period);
    put_reg(RegWdgCheck, next_cfg.wdg_check_period);
    put_reg(RegWdgDelay, next_cfg.wdg_start_delay);
    // top data bit is not part of the threshold
    put_reg(RegMoveThresh, {1'($urandom_range(0, 1)), next_cfg.move_threshold});
    if (with_unused) put_reg(RegUnused, PeriodW'($urandom));
    cfg_valid <= 1'b0;
    cur_thresh = next_cfg.move_threshold;
  endtask

  function automatic cfg_regs_t random_cfg(int period_max);
    cfg_regs_t c;
    c.led_timeout_period = PeriodW'($urandom_range(1, period_max));
    c.led_debug_period = PeriodW'($urandom_range(1, period_max));
    c.led_move_period = PeriodW'($urandom_range(1, period_max));
    c.led_normal_period = PeriodW'($urandom_range(1, period_max));
    c.wdg_check_period = PeriodW'($urandom_range(1, 400));
    c.wdg_start_delay = PeriodW'($urandom_range(0, 5000));
    c.move_threshold = ThreshW'($urandom_range(0, 50));
    return c;
  endfunction

  function automatic in_word_t mk_tick(logic [PeriodW-1:0] el, logic [3:0] flags,
                                       logic [SpeedW-1:0] tl, logic [SpeedW-1:0] tr,
                                       logic [SpeedW-1:0] ml, logic [SpeedW-1:0] mr,
                                       logic ok);
    in_word_t t;
    t.elapsed_ms = el;
    {t.estop, t.ultra_stop, t.link_timeout, t.debug_mode} = flags;
    t.target_left = tl;
    t.target_right = tr;
    t.measured_left = ml;
    t.measured_right = mr;
    t.all_healthy = ok;
    return t;
  endfunction

  function automatic logic [SpeedW-1:0] rand_speed();
    int r, m;
    r = $urandom_range(0, 9);
    m = int'(cur_thresh) + $urandom_range(0, 2) - 1;
    case (r)
      0, 1, 2, 3: return '0;
      4, 5: return $urandom_range(0, 1) ? SpeedW'(m) : SpeedW'(-m);
      6: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return SpeedW'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_tick();
    in_word_t    t;
    logic [95:0] raw;
    if ($urandom_range(0, 99) < 8) begin
      raw = {$urandom, $urandom, $urandom};
      t = raw[$bits(in_word_t)-1:0];
      return t;
    end
    t.elapsed_ms = ($urandom_range(0, 19) == 0) ? PeriodW'($urandom)
                                                : PeriodW'($urandom_range(0, el_max));
    t.estop = ($urandom_range(0, 99) < stop_pct);
    t.ultra_stop = ($urandom_range(0, 99) < stop_pct);
    t.link_timeout = ($urandom_range(0, 5) == 0);
    t.debug_mode = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 2) == 0) begin
      t.target_left = '0;
      t.target_right = '0;
      t.measured_left = '0;
      t.measured_right = '0;
    end else begin
      t.target_left = rand_speed();
      t.target_right = rand_speed();
      t.measured_left = rand_speed();
      t.measured_right = rand_speed();
    end
    t.all_healthy = ($urandom_range(0, 99) < healthy_pct);
    return t;
  endfunction

  task automatic run_ticks(int n);
    for (int i = 0; i < n; i++) send_tick(random_tick());
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    tx_gap_max = 16;
    rx_gap_max = 16;
    long_hold = 0;
    el_max = 300;
    healthy_pct = 60;
    stop_pct = 10;
    cur_thresh = MoveThreshReset;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: field extremes, forced-on, priorities, threshold edges
    send_tick(mk_tick(16'd0, Calm, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_tick(mk_tick(16'hFFFF, Calm, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd10, Estop, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd10, Ustop, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'hFFFF, Estop | Ustop, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1));
    send_tick(mk_tick(16'd99, Tmo, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd1, Tmo, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd250, Dbg, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd499, Calm, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd1, Calm, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd500, Calm, 16'h0000, 16'h0000, 16'h0006, 16'h0000, 1'b1));
    send_tick(mk_tick(16'd500, Calm, 16'h0000, 16'h0000, 16'h0000, 16'hFFFA, 1'b1));
    send_tick(mk_tick(16'd999, Calm, 16'h0005, 16'hFFFB, 16'h0005, 16'hFFFB, 1'b1));
    send_tick(mk_tick(16'd1, Calm, 16'h0005, 16'hFFFB, 16'h0005, 16'hFFFB, 1'b1));
    send_tick(mk_tick(16'd100, Tmo | Dbg, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b1));
    send_tick(mk_tick(16'd250, Dbg, 16'h0006, 16'h0006, 16'h0006, 16'h0006, 1'b1));
    send_tick(mk_tick(16'd100, Calm, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_tick(mk_tick(16'd0, Calm, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_tick(mk_tick(16'hFFFF, Estop | Ustop | Tmo | Dbg, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 1'b1));
    send_tick(mk_tick(16'd100, Calm, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 1'b1));
    run_ticks(40);
    drain();

    // zero periods and zero check period, unreachable start delay
    next_cfg = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 15'd0};
    program_regs(1'b1);
    healthy_pct = 90;
    run_ticks(100);
    drain();

    // long check period against the largest delay: healthy time saturates, then start
    next_cfg = random_cfg(600);
    next_cfg.wdg_check_period = 16'd40000;
    next_cfg.wdg_start_delay = 16'hFFFF;
    program_regs(1'b0);
    tx_gap_max = 0;
    el_max = 30000;
    healthy_pct = 92;
    run_ticks(120);
    drain();

    // every register at its maximum, no idling on either side
    next_cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF};
    program_regs(1'b1);
    rx_gap_max = 0;
    el_max = 65535;
    run_ticks(80);
    drain();

    // result side held off for a long stretch while ticks keep coming
    next_cfg = random_cfg(600);
    next_cfg.wdg_start_delay = 16'd0;
    program_regs(1'b0);
    rx_gap_max = 16;
    el_max = 300;
    long_hold = LongHold;
    run_ticks(100);
    drain();

    // frequent stops and poor health
    next_cfg = random_cfg(600);
    program_regs(1'b1);
    tx_gap_max = 16;
    rx_gap_max = 0;
    healthy_pct = 50;
    stop_pct = 30;
    run_ticks(100);
    drain();

    next_cfg = random_cfg(2000);
    program_regs(1'b0);
    rx_gap_max = 16;
    healthy_pct = 85;
    stop_pct = 10;
    el_max = 1500;
    run_ticks(100);
    drain();

    $display("%0d ticks over seven register settings, %0d with the led forced on", ticks,
             forced);
    $display("watchdog started %0d time(s), fed %0d times, %0d mismatches", starts, feeds,
             errors);
    if (errors == 0) begin
      $display("tb_status_led_watchdog_supervisor OK");
    end else begin
      $display("tb_status_led_watchdog_supervisor NOT OK");
    end
    $finish;
  end

endmodule
